/* src/gcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window scan package
// Shared widths, codes, payload types and the base classifier.
// ----------------------------------------------------------------------------
package gcw_pkg;

	// Ring of base classes: one entry per base of the longest window.
	localparam int MAX_WINDOW  = 1024;
	// Sequence position and whole-sequence counters stop at this value.
	localparam int MAX_SEQ_LEN = 16777216;
	// Fraction bits of the ratio; the quotient carries one more bit.
	localparam int RATIO_BITS  = 15;
	localparam int QUOT_W      = RATIO_BITS + 1;

	localparam int WIN_W   = 11;
	localparam int PTR_W   = $clog2(MAX_WINDOW);
	localparam int POS_W   = $clog2(MAX_SEQ_LEN) + 1;
	localparam int START_W = POS_W - 1;
	localparam int CLS_W   = 2;

	localparam logic [WIN_W-1:0] WIN_LEN_RESET = WIN_W'(100);

	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_C_LO = 8'h63;
	localparam logic [7:0] CH_C_UP = 8'h43;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_T_LO = 8'h74;
	localparam logic [7:0] CH_T_UP = 8'h54;

	localparam logic KIND_WIN = 1'b0;
	localparam logic KIND_TOT = 1'b1;

	typedef enum logic [CLS_W-1:0] {
		CLS_AT    = 2'd0,
		CLS_GC    = 2'd1,
		CLS_OTHER = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_LOAD,
		ST_DIV,
		ST_LOAD_TOT
	} state_t;

	typedef struct packed {
		logic [7:0] base;
		logic       seq_end;
	} in_t;

	typedef struct packed {
		logic               kind;
		logic [START_W-1:0] start_pos;
		logic [POS_W-1:0]   gc_total;
		logic [POS_W-1:0]   other_total;
		logic [QUOT_W-1:0]  gc_ratio;
		logic               ratio_valid;
		logic               last;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic upd;
		logic load;
		logic load_tot;
		logic push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic win_emit;
		logic is_end;
		logic div_busy;
		logic out_free;
		logic stage_tot;
	} stat_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		unique case (c)
			CH_G_LO, CH_G_UP, CH_C_LO, CH_C_UP: r = CLS_GC;
			CH_A_LO, CH_A_UP, CH_T_LO, CH_T_UP: r = CLS_AT;
			default:                            r = CLS_OTHER;
		endcase
		return r;
	endfunction

endpackage

/* src/gc_content_window_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC content window scan
// Sliding-window and whole-sequence G/C content of an ASCII nucleotide stream.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   gcw_pkg::in_t  (base, seq_end)
// out       output     out_valid / out_ready gcw_pkg::out_t (kind .. last)
// cfg       input      cfg_wr_en             cfg_wr_data    (window_len)
//
// A base takes an accept, an update and a load step; with no result it is
// done after those. Each result then runs through the divider and is
// pushed into the output register once that register is free.
// Reset is asynchronous and active low; it restores a window of 100 bases
// and clears all counters. The class ring itself is never cleared.
// A waiting result stalls only the next result push, not the next accept.
//
module gc_content_window_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gcw_pkg::WIN_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  gcw_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output gcw_pkg::out_t               out_data
);

	// The controller and datapath talk only through these two bundles.
	gcw_pkg::cmd_t  cmd;
	gcw_pkg::stat_t stat;

	// The controller walks each accepted base through its steps: update the
	// ring and counters, then stage a window result once the window is full and,
	// on a sequence's last base a totals result, each divided before its transfer.
	gcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the window length, the ring of base classes, the
	// window and sequence counters, the divider and the output register.
	// A window length write also restarts the current sequence.
	gcw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_data    (out_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

/* src/gcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window scan RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module gcw_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/gcw_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window scan divider
// Restoring divider, one quotient bit per cycle, for floor(num * 2^15 / den).
// ----------------------------------------------------------------------------
module gcw_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [gcw_pkg::POS_W-1:0]       num,
	input  logic [gcw_pkg::POS_W-1:0]       den,
	output logic                            busy,
	output logic [gcw_pkg::QUOT_W-1:0]      quot
);

	localparam int CNT_W = $clog2(gcw_pkg::QUOT_W + 1);

	// The numerator never exceeds the divisor, so the quotient fits in
	// QUOT_W bits and the partial remainder stays below twice the divisor.
	logic [gcw_pkg::POS_W:0]    rem_q;
	logic [gcw_pkg::POS_W-1:0]  den_q;
	logic [gcw_pkg::QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       ge;
	logic [gcw_pkg::POS_W:0]    rem_sub;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(gcw_pkg::QUOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= {rem_sub[gcw_pkg::POS_W-1:0], 1'b0};
			quot_q <= {quot_q[gcw_pkg::QUOT_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

/* src/gcw_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window scan datapath
// Class ring, window and sequence counters, result staging and output register.
// ----------------------------------------------------------------------------
module gcw_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gcw_pkg::WIN_W-1:0]   cfg_wr_data,
	input  gcw_pkg::in_t                in_data,
	output gcw_pkg::out_t               out_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  gcw_pkg::cmd_t               cmd,
	output gcw_pkg::stat_t              stat
);

	localparam int POS_W = gcw_pkg::POS_W;
	localparam int WIN_W = gcw_pkg::WIN_W;
	localparam int PTR_W = gcw_pkg::PTR_W;

	logic [WIN_W-1:0]   win_eff_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [POS_W-1:0]   pos_q;
	logic [WIN_W-1:0]   win_gc_q;
	logic [WIN_W-1:0]   win_oth_q;
	logic [POS_W-1:0]   seq_gc_q;
	logic [POS_W-1:0]   seq_oth_q;
	gcw_pkg::cls_t      cls_q;
	logic               end_q;
	logic               win_emit_q;
	gcw_pkg::out_t      stage_q;
	gcw_pkg::out_t      out_q;
	logic               out_valid_q;

	logic [gcw_pkg::CLS_W-1:0]  ram_rdata;
	gcw_pkg::cls_t              old_cls;
	logic [WIN_W-1:0]           cfg_eff;
	logic [POS_W-1:0]           w_pos;
	logic                       drop;
	logic                       gc_dec;
	logic                       oth_dec;
	logic                       is_gc;
	logic                       is_oth;
	logic [WIN_W-1:0]           ptr_inc;
	logic [PTR_W-1:0]           ptr_nx;
	logic                       pos_room;
	logic [POS_W-1:0]           pos_nx;
	logic [POS_W-1:0]           load_gc;
	logic [POS_W-1:0]           load_oth;
	logic [POS_W-1:0]           load_n;
	logic [POS_W-1:0]           load_den;
	logic [gcw_pkg::START_W-1:0] load_start;
	logic                       restart;
	logic                       div_busy;
	logic [gcw_pkg::QUOT_W-1:0] div_quot;
	gcw_pkg::out_t              push_data;

	// Window length zero counts as one; anything above the ring saturates.
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_eff = WIN_W'(1);
		end else if (cfg_wr_data > WIN_W'(gcw_pkg::MAX_WINDOW)) begin
			cfg_eff = WIN_W'(gcw_pkg::MAX_WINDOW);
		end else begin
			cfg_eff = cfg_wr_data;
		end
	end

	assign w_pos   = {{(POS_W - WIN_W){1'b0}}, win_eff_q};
	assign old_cls = gcw_pkg::cls_t'(ram_rdata);
	assign drop    = pos_q >= w_pos;
	assign is_gc   = cls_q == gcw_pkg::CLS_GC;
	assign is_oth  = cls_q == gcw_pkg::CLS_OTHER;
	assign gc_dec  = drop && old_cls == gcw_pkg::CLS_GC && win_gc_q != '0;
	assign oth_dec = drop && old_cls == gcw_pkg::CLS_OTHER && win_oth_q != '0;
	assign ptr_inc = {{(WIN_W - PTR_W){1'b0}}, ptr_q} + WIN_W'(1);
	assign ptr_nx  = (ptr_inc >= win_eff_q) ? '0 : ptr_inc[PTR_W-1:0];
	assign pos_room = pos_q < POS_W'(gcw_pkg::MAX_SEQ_LEN);
	assign pos_nx  = pos_room ? pos_q + POS_W'(1) : pos_q;

	assign restart = cfg_wr_en || (cmd.push && stage_q.kind == gcw_pkg::KIND_TOT);

	gcw_ram #(
		.WIDTH (gcw_pkg::CLS_W),
		.DEPTH (gcw_pkg::MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (ptr_q),
		.wdata (cls_q),
		.re    (cmd.accept),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_eff_q  <= gcw_pkg::WIN_LEN_RESET;
			ptr_q      <= '0;
			pos_q      <= '0;
			win_gc_q   <= '0;
			win_oth_q  <= '0;
			seq_gc_q   <= '0;
			seq_oth_q  <= '0;
			end_q      <= 1'b0;
			win_emit_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				win_eff_q <= cfg_eff;
			end
			if (cmd.accept) begin
				end_q <= in_data.seq_end;
			end
			if (restart) begin
				ptr_q     <= '0;
				pos_q     <= '0;
				win_gc_q  <= '0;
				win_oth_q <= '0;
				seq_gc_q  <= '0;
				seq_oth_q <= '0;
			end else if (cmd.upd) begin
				ptr_q      <= ptr_nx;
				pos_q      <= pos_nx;
				win_gc_q   <= win_gc_q - WIN_W'(gc_dec) + WIN_W'(is_gc);
				win_oth_q  <= win_oth_q - WIN_W'(oth_dec) + WIN_W'(is_oth);
				seq_gc_q   <= seq_gc_q + POS_W'(pos_room && is_gc);
				seq_oth_q  <= seq_oth_q + POS_W'(pos_room && is_oth);
				win_emit_q <= pos_nx >= w_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cls_q <= gcw_pkg::classify(in_data.base);
		end
	end

	// Result staging: window or totals operands.
	always_comb begin
		if (cmd.load_tot) begin
			load_gc    = seq_gc_q;
			load_oth   = seq_oth_q;
			load_n     = pos_q;
			load_start = '0;
		end else begin
			load_gc    = {{(POS_W - WIN_W){1'b0}}, win_gc_q};
			load_oth   = {{(POS_W - WIN_W){1'b0}}, win_oth_q};
			load_n     = w_pos;
			load_start = gcw_pkg::START_W'(pos_q - w_pos);
		end
		load_den = (load_n >= load_oth) ? load_n - load_oth : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stage_q.kind        <= cmd.load_tot ? gcw_pkg::KIND_TOT : gcw_pkg::KIND_WIN;
			stage_q.start_pos   <= load_start;
			stage_q.gc_total    <= load_gc;
			stage_q.other_total <= load_oth;
			stage_q.gc_ratio    <= '0;
			stage_q.ratio_valid <= load_den != '0;
			stage_q.last        <= cmd.load_tot || !end_q;
		end
	end

	gcw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.num    (load_gc),
		.den    (load_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The staged result with the quotient merged in; a zero divisor gives zero.
	always_comb begin
		push_data          = stage_q;
		push_data.gc_ratio = stage_q.ratio_valid ? div_quot : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.win_emit  = win_emit_q;
	assign stat.is_end    = end_q;
	assign stat.div_busy  = div_busy;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.stage_tot = stage_q.kind == gcw_pkg::KIND_TOT;

endmodule

/* src/gcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window scan controller
// Sequences accept, counter update, division and result transfer per base.
// ----------------------------------------------------------------------------
module gcw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gcw_pkg::stat_t  stat,
	output gcw_pkg::cmd_t   cmd
);

	gcw_pkg::state_t state_q;
	gcw_pkg::state_t state_nx;
	logic            div_out;

	assign div_out = !stat.div_busy && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			gcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = gcw_pkg::ST_UPD;
				end
			end
			gcw_pkg::ST_UPD: begin
				state_nx = gcw_pkg::ST_LOAD;
			end
			gcw_pkg::ST_LOAD: begin
				if (stat.win_emit || stat.is_end) begin
					state_nx = gcw_pkg::ST_DIV;
				end else begin
					state_nx = gcw_pkg::ST_IDLE;
				end
			end
			gcw_pkg::ST_DIV: begin
				if (div_out) begin
					if (!stat.stage_tot && stat.is_end) begin
						state_nx = gcw_pkg::ST_LOAD_TOT;
					end else begin
						state_nx = gcw_pkg::ST_IDLE;
					end
				end
			end
			gcw_pkg::ST_LOAD_TOT: begin
				state_nx = gcw_pkg::ST_DIV;
			end
			default: begin
				state_nx = gcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gcw_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			gcw_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
			end
			gcw_pkg::ST_LOAD: begin
				cmd.load     = stat.win_emit || stat.is_end;
				cmd.load_tot = !stat.win_emit;
			end
			gcw_pkg::ST_DIV: begin
				cmd.push = div_out;
			end
			gcw_pkg::ST_LOAD_TOT: begin
				cmd.load     = 1'b1;
				cmd.load_tot = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* src/gcw_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window scan checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module gcw_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input gcw_pkg::out_t  out_data
);

	// A result left waiting keeps its contents until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// A base is processed alone: no second transfer right after one.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// A zero divisor forces the ratio to zero.
	a_ratio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.ratio_valid || out_data.gc_ratio == '0)
		else $error("invalid ratio is not zero");

	// The ratio never exceeds one.
	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gc_ratio <= (16'(1) << gcw_pkg::RATIO_BITS))
		else $error("ratio above one");

	// Totals always close the item and carry start zero.
	a_tot_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == gcw_pkg::KIND_TOT |->
			out_data.last && out_data.start_pos == '0)
		else $error("totals result malformed");

endmodule

bind gc_content_window_scan gcw_chk u_gcw_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* tb/gc_content_window_scan_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC content window scan testbench
// Streams ASCII bases through the scanner under several window lengths and
// idle/stall patterns. An in-bench model of the window and sequence counters
// predicts every window and totals result, and the monitor checks each output
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module gc_content_window_scan_tb;
	import gcw_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 12;
	// A base with both a window and a totals result takes longest; this pad
	// covers a base that is still in work with nothing left to expect.
	localparam int DRAIN_PAD    = 80;
	// Longest run of cycles without any transfer while work is outstanding. The
	// long receiver hold-off plus a full divider pass fits well inside it.
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 500;
	localparam int MAX_REPORTS  = 10;

	// Base mixes for random sequences.
	typedef enum int {
		MIX_EVEN,
		MIX_GC_RICH,
		MIX_OTHER_RICH,
		MIX_AT_ONLY
	} mix_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en = 1'b0;
	logic [WIN_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;

	gc_content_window_scan u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// Bases waiting to be offered, and results the scanner still owes us.
	in_t  bases_q[$];
	out_t due_results[$];

	int n_queued = 0;
	int n_taken  = 0;
	int n_bad    = 0;
	int quiet_cycles = 0;

	// Idle control shared between the stimulus thread and the two drivers.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	bit base_took = 1'b0;

	// Model state: class ring, ring pointer, window and sequence counters.
	cls_t             ring_cls [MAX_WINDOW];
	logic [WIN_W-1:0] win_len_reg;
	logic [PTR_W-1:0] ring_at;
	logic [POS_W-1:0] bases_seen;
	logic [WIN_W-1:0] win_gc_cnt;
	logic [WIN_W-1:0] win_other_cnt;
	logic [POS_W-1:0] seq_gc_cnt;
	logic [POS_W-1:0] seq_other_cnt;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Scan model
	// ------------------------------------------------------------------------

	function automatic cls_t class_of(input logic [7:0] b);
		cls_t c;
		case (b)
			CH_G_LO, CH_G_UP, CH_C_LO, CH_C_UP: c = CLS_GC;
			CH_A_LO, CH_A_UP, CH_T_LO, CH_T_UP: c = CLS_AT;
			default:                            c = CLS_OTHER;
		endcase
		return c;
	endfunction

	// A programmed length of zero acts as one; anything past the ring depth
	// is clipped to it.
	function automatic int eff_window_len();
		int w;
		w = int'(win_len_reg);
		if (w == 0)
			w = 1;
		if (w > MAX_WINDOW)
			w = MAX_WINDOW;
		return w;
	endfunction

	function automatic void restart_scan();
		ring_at       = '0;
		bases_seen    = '0;
		win_gc_cnt    = '0;
		win_other_cnt = '0;
		seq_gc_cnt    = '0;
		seq_other_cnt = '0;
	endfunction

	// Build one result; the ratio is G/C over the A/T/G/C bases, scaled by
	// 2^RATIO_BITS and rounded down, and invalid when no such base exists.
	function automatic out_t make_result(input logic kind, input logic [START_W-1:0] start,
	                                     input logic [POS_W-1:0] gc,
	                                     input logic [POS_W-1:0] other,
	                                     input logic [POS_W-1:0] n, input logic last_flag);
		out_t             r;
		logic [POS_W-1:0] divisor;
		logic [63:0]      quot;
		divisor       = (n >= other) ? n - other : '0;
		r.kind        = kind;
		r.start_pos   = start;
		r.gc_total    = gc;
		r.other_total = other;
		r.last        = last_flag;
		if (divisor != '0) begin
			quot          = (64'(gc) << RATIO_BITS) / 64'(divisor);
			r.gc_ratio    = quot[QUOT_W-1:0];
			r.ratio_valid = 1'b1;
		end else begin
			r.gc_ratio    = '0;
			r.ratio_valid = 1'b0;
		end
		return r;
	endfunction

	// Advance the model by one accepted base and queue what it must produce.
	function automatic void scan_base(input in_t item);
		int   w;
		int   p;
		cls_t c;
		w = eff_window_len();
		p = int'(ring_at);
		c = class_of(item.base);
		// Once the window is full, the oldest base slides out of the counts.
		if (bases_seen >= w) begin
			if (ring_cls[p] == CLS_GC && win_gc_cnt != '0)
				win_gc_cnt--;
			else if (ring_cls[p] == CLS_OTHER && win_other_cnt != '0)
				win_other_cnt--;
		end
		ring_cls[p] = c;
		ring_at = (p + 1 >= w) ? '0 : PTR_W'(p + 1);
		if (c == CLS_GC)
			win_gc_cnt++;
		else if (c == CLS_OTHER)
			win_other_cnt++;
		// Sequence counters saturate at the maximum sequence length.
		if (bases_seen < MAX_SEQ_LEN) begin
			bases_seen++;
			if (c == CLS_GC)
				seq_gc_cnt++;
			else if (c == CLS_OTHER)
				seq_other_cnt++;
		end
		if (bases_seen >= w)
			due_results.push_back(make_result(KIND_WIN, START_W'(bases_seen - w),
				POS_W'(win_gc_cnt), POS_W'(win_other_cnt), POS_W'(w), !item.seq_end));
		if (item.seq_end) begin
			due_results.push_back(make_result(KIND_TOT, '0, seq_gc_cnt, seq_other_cnt,
				bases_seen, 1'b1));
			restart_scan();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Input driver: changes at the falling edge. A new base is offered only
	// when the channel is empty or the previous one was just transferred, so
	// valid and payload hold steady until the scanner takes them.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || base_took) begin
			if (bases_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= bases_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output receiver: random stalls, plus one long hold-off on request that
	// lets the result path back up until the input side stops taking bases.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. Input transfers feed
	// the model, output transfers are checked against the oldest prediction,
	// and the watchdog ends the run if work is outstanding but nothing moves.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_t want;
		if (in_valid && in_ready) begin
			scan_base(in_data);
			n_taken++;
		end
		base_took <= in_valid && in_ready;

		if (out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				if (n_bad < MAX_REPORTS)
					$display("%0t: result transfer with nothing expected: %p",
						$time, out_data);
				n_bad++;
			end else begin
				want = due_results.pop_front();
				if (out_data !== want) begin
					if (n_bad < MAX_REPORTS) begin
						$display("%0t: result mismatch", $time);
						$write("  expected kind=%0d start=%0d gc=%0d other=%0d",
							want.kind, want.start_pos, want.gc_total, want.other_total);
						$display(" ratio=%0d valid=%0d last=%0d",
							want.gc_ratio, want.ratio_valid, want.last);
						$write("  actual   kind=%0d start=%0d gc=%0d other=%0d",
							out_data.kind, out_data.start_pos, out_data.gc_total,
							out_data.other_total);
						$display(" ratio=%0d valid=%0d last=%0d",
							out_data.gc_ratio, out_data.ratio_valid, out_data.last);
					end
					n_bad++;
				end
			end
		end

		if ((in_valid && in_ready) || (out_valid && out_ready) ||
		    (n_taken == n_queued && due_results.size() == 0)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic push_base(input logic [7:0] b, input logic last_base);
		in_t item;
		item.base    = b;
		item.seq_end = last_base;
		bases_q.push_back(item);
		n_queued++;
	endtask

	// One whole sequence; the last character carries the end mark.
	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_base(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_base(input mix_t mix);
		logic [7:0] gc_chars [4];
		logic [7:0] at_chars [4];
		int         gc_pct;
		int         other_pct;
		int         roll;
		gc_chars = '{CH_G_LO, CH_G_UP, CH_C_LO, CH_C_UP};
		at_chars = '{CH_A_LO, CH_A_UP, CH_T_LO, CH_T_UP};
		case (mix)
			MIX_EVEN:       begin gc_pct = 40; other_pct = 20; end
			MIX_GC_RICH:    begin gc_pct = 90; other_pct = 3;  end
			MIX_OTHER_RICH: begin gc_pct = 10; other_pct = 80; end
			default:        begin gc_pct = 0;  other_pct = 0;  end
		endcase
		roll = $urandom_range(99);
		if (roll < gc_pct)
			return gc_chars[$urandom_range(3)];
		// Any byte may land here, letters included; that only shifts the mix.
		if (roll < gc_pct + other_pct)
			return 8'($urandom_range(255));
		return at_chars[$urandom_range(3)];
	endfunction

	// Random sequence with one mix throughout. An open sequence has no end
	// mark and is cut short by the next register write.
	task automatic push_random_seq(input int len, input bit closed);
		mix_t mix;
		int   roll;
		roll = $urandom_range(9);
		if (roll < 6)
			mix = MIX_EVEN;
		else if (roll < 8)
			mix = MIX_GC_RICH;
		else if (roll < 9)
			mix = MIX_OTHER_RICH;
		else
			mix = MIX_AT_ONLY;
		for (int i = 0; i < len; i++)
			push_base(pick_base(mix), closed && i == len - 1);
	endtask

	// Mostly sequences that fill the window or run past it, some no longer than it.
	// Long windows get sequences at or just past their length.
	function automatic int pick_len(input int w);
		if (w > 64)
			return w + $urandom_range(15);
		if ($urandom_range(9) < 7)
			return w + $urandom_range(2 * w + 8);
		return $urandom_range(w, 1);
	endfunction

	// Wait until every base is in and every result is out, then give a base
	// that yields nothing time to finish before anything is reprogrammed.
	task automatic settle();
		while (n_taken != n_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Register write with the scanner idle; a write also restarts the sequence.
	task automatic write_window(input logic [WIN_W-1:0] len);
		settle();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		win_len_reg = len;
		restart_scan();
	endtask

	task automatic run_phase(input logic [WIN_W-1:0] len, input int n_bases,
	                         input int snd_pct, input int rcv_pct, input bit long_hold);
		int w;
		int first;
		write_window(len);
		w = eff_window_len();
		send_idle_pct  = snd_pct;
		recv_stall_pct = rcv_pct;
		first = n_queued;
		while (n_queued - first < n_bases)
			push_random_seq(pick_len(w), 1'b1);
		if ($urandom_range(1) == 1)
			push_random_seq($urandom_range((w < 40) ? w : 40, 1), 1'b0);
		if (long_hold)
			hold_req = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		win_len_reg = WIN_LEN_RESET;
		restart_scan();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset window of 100: a short sequence gives totals only.
		push_text("AcGt");

		// Window of one: every base is its own window. An unknown letter gives
		// a window with no divisor; the byte extremes are classed as other.
		write_window(11'd1);
		push_text("GcaTN");
		push_base(8'h00, 1'b0);
		push_base(8'hFF, 1'b0);
		push_text("gC");

		// Zero length acts as one; a lone unknown base leaves both the window
		// and the totals without a divisor.
		write_window(11'd0);
		push_text("AN");
		push_text("N");

		// Window of three: all-G/C windows hit the full-scale ratio, then a
		// sequence of unknowns only.
		write_window(11'd3);
		push_text("GGCG");
		push_text("NNN");

		// All ones saturates to the ring depth; short sequence, totals only.
		write_window(11'h7FF);
		push_text("ac");

		// Random phases. The first one runs without idling while the receiver
		// holds off for a long stretch so that the input side backs up.
		run_phase(11'd5, 150, 0, 0, 1'b1);
		run_phase(11'd16, 100, 70, 0, 1'b0);
		run_phase(11'd1, 100, 0, 70, 1'b0);
		run_phase(11'd37, 100, 25, 25, 1'b0);
		run_phase(11'd200, 1, 25, 25, 1'b0);
		run_phase(WIN_W'($urandom_range(64, 2)), 60, 0, 0, 1'b0);

		settle();
		if (n_bad == 0 && due_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
src/gcw_pkg.sv
src/gcw_ram.sv
src/gcw_div.sv
src/gcw_dp.sv
src/gcw_ctrl.sv
src/gc_content_window_scan.sv
src/gcw_chk.sv
tb/gc_content_window_scan_tb.sv
